@@ design/assert_macros.svh @@
// Assertion macros shared by the servo pulse calibrator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// When the condition holds at a clock edge, the property must hold at that same edge.
`define ASSERT_IMPLIES(name, clock, rst_n, cond, prop) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("assertion failed: same-cycle implication violated");

// When the condition holds at a clock edge, the property must hold at the next edge.
`define ASSERT_NEXT(name, clock, rst_n, cond, prop) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_IMPLIES(name, clock, rst_n, cond, prop)
`define ASSERT_NEXT(name, clock, rst_n, cond, prop)

`endif

`endif

@@ design/spc_pkg.sv @@
// Package for the servo pulse calibrator: item structs, operation and phase codes,
// pulse constants and the widths of the shared bit-serial multiplier. No dependencies.
package spc_pkg;

	// Widths of the item fields.
	localparam int OP_W    = 3;
	localparam int CODE_W  = 6;
	localparam int PULSE_W = 11;
	localparam int PWM_W   = 16;

	// Operation codes carried in the op field; the other codes do nothing.
	localparam logic [OP_W-1:0] OP_CMD   = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 3'd1;
	localparam logic [OP_W-1:0] OP_LEFT  = 3'd2;
	localparam logic [OP_W-1:0] OP_RIGHT = 3'd3;
	localparam logic [OP_W-1:0] OP_START = 3'd4;

	// Calibration phases.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEFT,
		PH_DWELL,
		PH_RIGHT
	} phase_t;

	// Pulse widths in microseconds.
	localparam logic [PULSE_W-1:0] US_MIN  = 11'd1000;
	localparam logic [PULSE_W-1:0] US_MID  = 11'd1500;
	localparam logic [PULSE_W-1:0] US_MAX  = 11'd2000;
	localparam logic [PULSE_W-1:0] US_STEP = 11'd100;

	// Sweep time counter saturates at its full scale.
	localparam int ELAPSED_W = 11;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 11'd2047;

	// Position code that maps to the centre pulse.
	localparam logic [CODE_W-1:0] CENTRE_CODE = 6'd31;

	// Cube of the position offset, and its scaled form (cube * 1008).
	localparam int CUBE_W   = 16;
	localparam int SCALED_W = 26;
	localparam int DELTA_W  = 10;

	// PWM compare level is pulse * 22370 >> 10.
	localparam int PWM_SHIFT = 10;

	// Shift-add multiplier: multiplicand, multiplier and product widths.
	localparam int MUL_AW = 15;
	localparam int MUL_BW = 11;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_CW = $clog2(MUL_BW + 1);

	localparam logic [MUL_AW-1:0] PWM_GAIN = 15'd22370;

	// One input item.
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [CODE_W-1:0] position_code;
	} evt_item_t;

	// One result item.
	typedef struct packed {
		logic [PWM_W-1:0]   pwm_level;
		logic [PULSE_W-1:0] pulse_width_us;
		logic [1:0]         phase;
		logic               timeout_error;
		logic               command_ignored;
		logic [PULSE_W-1:0] safe_left_us;
		logic [PULSE_W-1:0] safe_right_us;
	} rpt_item_t;

	// Request from the sequencer to the calibration state.
	typedef struct packed {
		logic               apply;
		logic [OP_W-1:0]    op;
		logic [PULSE_W-1:0] cmd_pulse;
	} calib_req_t;

	// Visible calibration state.
	typedef struct packed {
		phase_t             phase;
		logic [PULSE_W-1:0] driven;
		logic [PULSE_W-1:0] left_limit;
		logic [PULSE_W-1:0] right_limit;
		logic               timed_out;
		logic               ignored;
	} calib_status_t;

endpackage

@@ design/servo_pulse_calibrator_unit.sv @@
// Top level of the servo pulse calibrator: item sequencer, output register and the
// shared bit-serial multiplier. Depends on spc_pkg, spc_serial_mul, spc_calib.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  evt     | evt_valid/evt_ready  | evt_item: op, position_code
//  rpt     | rpt_valid/rpt_ready  | rpt_item: pwm level, pulse, phase, flags, limits
//
// Every item uses one 11-bit shift-add multiplier, which loads its operands, steps through
// the multiplier bits and then finishes each product. A tick, switch or start item needs one
// product; a position command while idle needs two more products (offset squared, then
// cubed). One item is in work at a time. A finished result waits in the
// output register while the next item is accepted; a stalled output holds the
// sequencer only once the following result is ready. Reset is asynchronous.
`include "assert_macros.svh"

module servo_pulse_calibrator_unit #(
	parameter int DWELL_TICKS   = 50,
	parameter int TIMEOUT_TICKS = 2000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evt_valid,
	output logic               evt_ready,
	input  spc_pkg::evt_item_t evt_item,
	output logic               rpt_valid,
	input  logic               rpt_ready,
	output spc_pkg::rpt_item_t rpt_item
);
	import spc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQ,
		S_CUBE,
		S_APPLY,
		S_PWM,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [OP_W-1:0]    op_q;
	logic [CODE_W-1:0]  mag_q;
	logic               pos_q;
	logic [PULSE_W-1:0] map_q;
	logic [PWM_W-1:0]   pwm_q;
	logic               mul_start_q;
	logic               rpt_valid_q;
	rpt_item_t          rpt_q;

	logic [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]  mul_b;
	logic               mul_busy;
	logic               mul_done;
	logic [MUL_PW-1:0]  mul_product;

	calib_req_t         calib_req;
	calib_status_t      calib_status;

	logic               accept;
	logic               map_path;
	logic [CODE_W-1:0]  mag_in;
	logic [CUBE_W-1:0]  cube;
	logic [SCALED_W-1:0] scaled;
	logic [DELTA_W-1:0] delta;
	logic [PULSE_W-1:0] map_raw;
	logic [PULSE_W-1:0] map_clamped;

	assign evt_ready = (state_q == S_IDLE);
	assign accept    = evt_valid && evt_ready;
	assign map_path  = (evt_item.op == OP_CMD) && (calib_status.phase == PH_IDLE);

	// Distance of the position code from centre.
	assign mag_in = (evt_item.position_code >= CENTRE_CODE) ?
		evt_item.position_code - CENTRE_CODE : CENTRE_CODE - evt_item.position_code;

	// Operand selection for the shared multiplier, by sequencer state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				mul_a = MUL_AW'(mag_q);
				mul_b = MUL_BW'(mag_q);
			end
			S_CUBE: begin
				mul_a = mul_product[MUL_AW-1:0];
				mul_b = MUL_BW'(mag_q);
			end
			S_PWM: begin
				mul_a = PWM_GAIN;
				mul_b = calib_status.driven;
			end
			default: begin
			end
		endcase
	end

	// Cube times 1008 is the cube times 1024 less the cube times 16; keep the top bits.
	assign cube    = mul_product[CUBE_W-1:0];
	assign scaled  = {cube, 10'b0} - {6'b0, cube, 4'b0};
	assign delta   = scaled[SCALED_W-1:SCALED_W-DELTA_W];
	assign map_raw = pos_q ? US_MID + PULSE_W'(delta) : US_MID - PULSE_W'(delta);

	// Clamp the mapped command to the learned limits, then to the absolute range.
	always_comb begin
		map_clamped = map_q;
		if (map_clamped < calib_status.left_limit) begin
			map_clamped = calib_status.left_limit;
		end
		if (map_clamped > calib_status.right_limit) begin
			map_clamped = calib_status.right_limit;
		end
		if (map_clamped < US_MIN) begin
			map_clamped = US_MIN;
		end
		if (map_clamped > US_MAX) begin
			map_clamped = US_MAX;
		end
	end

	assign calib_req.apply     = (state_q == S_APPLY);
	assign calib_req.op        = op_q;
	assign calib_req.cmd_pulse = map_clamped;

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			mag_q       <= '0;
			pos_q       <= 1'b0;
			map_q       <= US_MID;
			pwm_q       <= '0;
			mul_start_q <= 1'b0;
			rpt_valid_q <= 1'b0;
			rpt_q       <= '0;
		end else begin
			mul_start_q <= 1'b0;
			if (rpt_valid_q && rpt_ready) begin
				rpt_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= evt_item.op;
						mag_q <= mag_in;
						pos_q <= (evt_item.position_code >= CENTRE_CODE);
						if (map_path) begin
							mul_start_q <= 1'b1;
							state_q     <= S_SQ;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_SQ: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						state_q     <= S_CUBE;
					end
				end
				S_CUBE: begin
					if (mul_done) begin
						map_q   <= map_raw;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					mul_start_q <= 1'b1;
					state_q     <= S_PWM;
				end
				S_PWM: begin
					if (mul_done) begin
						pwm_q   <= mul_product[PWM_SHIFT+PWM_W-1:PWM_SHIFT];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rpt_valid_q || rpt_ready) begin
						rpt_q.pwm_level       <= pwm_q;
						rpt_q.pulse_width_us  <= calib_status.driven;
						rpt_q.phase           <= calib_status.phase;
						rpt_q.timeout_error   <= calib_status.timed_out;
						rpt_q.command_ignored <= calib_status.ignored;
						rpt_q.safe_left_us    <= calib_status.left_limit;
						rpt_q.safe_right_us   <= calib_status.right_limit;
						rpt_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt_item  = rpt_q;

	spc_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_product)
	);

	spc_calib #(
		.DWELL_TICKS   (DWELL_TICKS),
		.TIMEOUT_TICKS (TIMEOUT_TICKS)
	) u_calib (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (calib_req),
		.status (calib_status)
	);

	// An accepted item closes the input until its result has been built.
	`ASSERT_NEXT(a_accept_closes_input, clk, arst_n, accept, !evt_ready)
	// While the input is open the multiplier has nothing in hand.
	`ASSERT_IMPLIES(a_idle_mul_quiet, clk, arst_n, evt_ready, !mul_busy && !mul_start_q)
	// A product is only requested when the multiplier is free.
	`ASSERT_IMPLIES(a_start_when_free, clk, arst_n, mul_start_q, !mul_busy)
	// Every delivered pulse width lies in the servo's range.
	`ASSERT_IMPLIES(a_pulse_range, clk, arst_n, rpt_valid_q, (rpt_q.pulse_width_us >= US_MIN) && (rpt_q.pulse_width_us <= US_MAX))

endmodule

@@ design/spc_serial_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on spc_pkg for its operand and product widths.
module spc_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [spc_pkg::MUL_AW-1:0]  a,
	input  logic [spc_pkg::MUL_BW-1:0]  b,
	output logic                        busy,
	output logic                        done,
	output logic [spc_pkg::MUL_PW-1:0]  product
);
	import spc_pkg::*;

	logic [MUL_AW-1:0] a_q;
	logic [MUL_PW-1:0] acc_q;
	logic [MUL_CW-1:0] cnt_q;
	logic              run_q;
	logic              done_q;
	logic [MUL_AW:0]   upper_sum;

	// The multiplier sits in the low bits of the accumulator; each step adds the
	// multiplicand into the upper half when the current low bit is set, then shifts right.
	assign upper_sum = {1'b0, acc_q[MUL_PW-1:MUL_BW]} + (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q   <= a;
				acc_q <= {{MUL_AW{1'b0}}, b};
				cnt_q <= MUL_CW'(MUL_BW);
				run_q <= 1'b1;
			end else if (run_q) begin
				acc_q <= {upper_sum, acc_q[MUL_BW-1:1]};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy    = run_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ design/spc_calib.sv @@
// Calibration state of the servo pulse calibrator: phase, sweep counters, trial and
// held pulses, learned limits and the sticky timeout flag. Depends on spc_pkg.
module spc_calib #(
	parameter int DWELL_TICKS   = 50,
	parameter int TIMEOUT_TICKS = 2000
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  spc_pkg::calib_req_t    req,
	output spc_pkg::calib_status_t status
);
	import spc_pkg::*;

	localparam int DW = $clog2(DWELL_TICKS + 1);

	phase_t             phase_q,   phase_n;
	logic [DW-1:0]      dwell_q,   dwell_n;
	logic [ELAPSED_W-1:0] elapsed_q, elapsed_n;
	logic [PULSE_W-1:0] driven_q,  driven_n;
	logic [PULSE_W-1:0] trial_q,   trial_n;
	logic [PULSE_W-1:0] held_q,    held_n;
	logic               seeking_q, seeking_n;
	logic [PULSE_W-1:0] left_q,    left_n;
	logic [PULSE_W-1:0] right_q,   right_n;
	logic               timed_q,   timed_n;
	logic               ignored_q, ignored_n;

	// Next state for one applied item.
	always_comb begin
		logic [DW-1:0]        dwell_inc;
		logic [ELAPSED_W-1:0] elapsed_inc;
		logic [PULSE_W-1:0]   held_tmp;
		logic [PULSE_W-1:0]   trial_tmp;

		dwell_inc   = dwell_q + 1'b1;
		elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 1'b1 : elapsed_q;
		held_tmp    = seeking_q ? trial_q : held_q;
		trial_tmp   = '0;

		phase_n   = phase_q;
		dwell_n   = dwell_q;
		elapsed_n = elapsed_q;
		driven_n  = driven_q;
		trial_n   = trial_q;
		held_n    = held_q;
		seeking_n = seeking_q;
		left_n    = left_q;
		right_n   = right_q;
		timed_n   = timed_q;
		ignored_n = ignored_q;

		if (req.apply) begin
			ignored_n = 1'b0;
			unique case (req.op)
				OP_CMD: begin
					if (phase_q != PH_IDLE) begin
						ignored_n = 1'b1;
					end else begin
						driven_n = req.cmd_pulse;
					end
				end
				OP_TICK: begin
					if (phase_q != PH_IDLE) begin
						elapsed_n = elapsed_inc;
						if (dwell_inc < DW'(DWELL_TICKS)) begin
							dwell_n = dwell_inc;
						end else begin
							dwell_n = '0;
							if (phase_q == PH_DWELL) begin
								// Centre dwell over: the right sweep starts one step out.
								phase_n   = PH_RIGHT;
								seeking_n = 1'b1;
								held_n    = US_MID;
								elapsed_n = '0;
								trial_n   = US_MID + US_STEP;
								driven_n  = US_MID + US_STEP;
							end else begin
								held_n = held_tmp;
								if (elapsed_inc >= ELAPSED_W'(TIMEOUT_TICKS)) begin
									// The sweep ran too long: abandon the calibration.
									timed_n   = 1'b1;
									seeking_n = 1'b0;
									phase_n   = PH_IDLE;
								end else if (!seeking_q) begin
									// A switch was hit during this sweep: learn the limit.
									if (phase_q == PH_LEFT) begin
										left_n    = held_tmp;
										driven_n  = US_MID;
										phase_n   = PH_DWELL;
										elapsed_n = '0;
									end else begin
										right_n = held_tmp;
										phase_n = PH_IDLE;
									end
								end else begin
									// Still seeking: step the trial pulse on, clamped.
									if (phase_q == PH_LEFT) begin
										trial_tmp = (held_tmp >= US_MIN + US_STEP) ?
											held_tmp - US_STEP : US_MIN;
									end else begin
										trial_tmp = (held_tmp <= US_MAX - US_STEP) ?
											held_tmp + US_STEP : US_MAX;
									end
									trial_n  = trial_tmp;
									driven_n = trial_tmp;
								end
							end
						end
					end
				end
				OP_LEFT: begin
					driven_n  = left_q;
					seeking_n = 1'b0;
				end
				OP_RIGHT: begin
					driven_n  = right_q;
					seeking_n = 1'b0;
				end
				OP_START: begin
					phase_n   = PH_LEFT;
					seeking_n = 1'b1;
					held_n    = US_MID;
					dwell_n   = '0;
					elapsed_n = '0;
					trial_n   = US_MID - US_STEP;
					driven_n  = US_MID - US_STEP;
				end
				default: begin
				end
			endcase
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			dwell_q   <= '0;
			elapsed_q <= '0;
			driven_q  <= US_MID;
			trial_q   <= US_MID;
			held_q    <= US_MID;
			seeking_q <= 1'b0;
			left_q    <= US_MIN;
			right_q   <= US_MAX;
			timed_q   <= 1'b0;
			ignored_q <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			dwell_q   <= dwell_n;
			elapsed_q <= elapsed_n;
			driven_q  <= driven_n;
			trial_q   <= trial_n;
			held_q    <= held_n;
			seeking_q <= seeking_n;
			left_q    <= left_n;
			right_q   <= right_n;
			timed_q   <= timed_n;
			ignored_q <= ignored_n;
		end
	end

	assign status.phase       = phase_q;
	assign status.driven      = driven_q;
	assign status.left_limit  = left_q;
	assign status.right_limit = right_q;
	assign status.timed_out   = timed_q;
	assign status.ignored     = ignored_q;

endmodule
